// ===== sv/btpc_pkg.sv =====
// ----------------------------------------------------------------------------
// btpc_pkg
// types, constants and arithmetic helpers shared by the compensation pipeline
// ----------------------------------------------------------------------------
package btpc_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_TEMP      = 2'd0;
    localparam logic [1:0] CFG_PRES_LOW  = 2'd1;
    localparam logic [1:0] CFG_PRES_MID  = 2'd2;
    localparam logic [1:0] CFG_PRES_HIGH = 2'd3;

    localparam int CFG_WIDTH  = 48;
    localparam int DIV_STEPS  = 64;

    localparam int T_OFFSET   = 128000;
    localparam int P_BASE     = 1048576;
    localparam int P_SCALE    = 3125;
    localparam int P4_SHIFT   = 35;
    localparam int P1_ONE     = 47;
    localparam int P1_SHIFT   = 33;
    localparam int P5_SHIFT   = 17;
    localparam int P2_SHIFT   = 12;
    localparam int T2_SHIFT   = 11;
    localparam int T3_SHIFT   = 14;
    localparam int SQ_SHIFT   = 12;
    localparam int NUM_SHIFT  = 31;
    localparam int PS_SHIFT   = 13;
    localparam int P9_SHIFT   = 25;
    localparam int P8_SHIFT   = 19;
    localparam int P3_SHIFT   = 8;
    localparam int OUT_SHIFT  = 8;
    localparam int P7_SHIFT   = 4;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] fine_temperature;
        logic signed [15:0] temperature_centi;
        logic [31:0]        pressure_q24_8;
        logic               divide_error;
    } t_out_item;

    typedef struct packed {
        logic [15:0]        t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic [15:0]        p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } t_coef;

    // temperature results carried alongside the pressure work
    typedef struct packed {
        logic signed [31:0] tf;
        logic signed [15:0] tc;
    } t_temp;

    // partial products of a 64 x 64 multiply, low 64 bits only
    typedef struct packed {
        logic [63:0] ll;
        logic [31:0] lh;
        logic [31:0] hl;
    } t_pp;

    // one step of the restoring divider
    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] quo;
        logic [63:0] dvs;
        logic        neg;
        logic        err;
        t_temp       side;
    } t_div;

    function automatic t_pp pp_mul(input logic [63:0] a, input logic [63:0] b);
        t_pp r;
        r.ll = a[31:0] * b[31:0];
        r.lh = a[31:0] * b[63:32];
        r.hl = a[63:32] * b[31:0];
        return r;
    endfunction

    function automatic logic [63:0] pp_sum(input t_pp p);
        return p.ll + {p.lh + p.hl, 32'd0};
    endfunction

    function automatic logic [63:0] asr64(input logic signed [63:0] x, input int unsigned n);
        return x >>> n;
    endfunction

    function automatic logic [63:0] sext16(input logic signed [15:0] w);
        return {{48{w[15]}}, w};
    endfunction

endpackage

// ===== sv/btpc_front.sv =====
// ----------------------------------------------------------------------------
// btpc_front
// temperature compensation and pressure numerator / denominator, 12 stages
// ----------------------------------------------------------------------------
module btpc_front import btpc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_in_item i_item,
    input  t_coef    i_coef,
    output logic     o_valid,
    output t_div     o_div
);

    logic [12:1] r_v;

    logic signed [17:0] r_s1_a;
    logic signed [16:0] r_s1_b;
    logic [19:0]        r_s1_adcp;
    logic signed [33:0] r_s2_at2;
    logic [31:0]        r_s2_bb;
    logic [19:0]        r_s2_adcp;
    logic signed [22:0] r_s3_v1;
    logic signed [36:0] r_s3_sqt3;
    logic [19:0]        r_s3_adcp;
    logic signed [31:0] r_s4_tf;
    logic [19:0]        r_s4_adcp;
    t_temp              r_s5_side;
    logic [63:0]        r_s5_x1sq;
    logic signed [40:0] r_s5_x1p5;
    logic signed [40:0] r_s5_x1p2;
    logic [19:0]        r_s5_adcp;
    t_temp              r_s6_side;
    t_pp                r_s6_pp6;
    t_pp                r_s6_pp3;
    logic signed [40:0] r_s6_x1p5;
    logic signed [40:0] r_s6_x1p2;
    logic [19:0]        r_s6_adcp;
    t_temp              r_s7_side;
    logic [63:0]        r_s7_q6;
    logic [63:0]        r_s7_q3;
    logic signed [40:0] r_s7_x1p5;
    logic signed [40:0] r_s7_x1p2;
    logic [19:0]        r_s7_adcp;
    t_temp              r_s8_side;
    logic [63:0]        r_s8_x2;
    logic [63:0]        r_s8_x1b;
    logic [19:0]        r_s8_adcp;
    t_temp              r_s9_side;
    t_pp                r_s9_pp1;
    logic [63:0]        r_s9_n0;
    t_temp              r_s10_side;
    logic [63:0]        r_s10_den;
    t_pp                r_s10_ppn;
    t_temp              r_s11_side;
    logic [63:0]        r_s11_den;
    logic [63:0]        r_s11_num;
    t_div               r_s12_div;

    logic signed [17:0] n_a;
    logic signed [16:0] n_b;
    logic signed [33:0] n_at2;
    logic signed [33:0] n_bb;
    logic signed [33:0] n_at2_sh;
    logic signed [36:0] n_sqt3;
    logic signed [36:0] n_sqt3_sh;
    logic signed [31:0] n_tf;
    logic signed [33:0] n_tf34;
    logic signed [33:0] n_tc_w;
    t_temp              n_side;
    logic signed [32:0] n_x1_w;
    logic signed [24:0] n_x1;
    logic signed [49:0] n_x1sq;
    logic signed [40:0] n_x1p5;
    logic signed [40:0] n_x1p2;
    logic [63:0]        n_x2;
    logic [63:0]        n_x1b;
    logic [20:0]        n_pb;
    logic [63:0]        n_n0;
    t_div               n_div;

    always_comb begin
        n_a = $signed({1'b0, i_item.raw_temperature[19:3]}) - $signed({1'b0, i_coef.t1, 1'b0});
        n_b = $signed({1'b0, i_item.raw_temperature[19:4]}) - $signed({1'b0, i_coef.t1});

        n_at2 = r_s1_a * i_coef.t2;
        n_bb  = r_s1_b * r_s1_b;

        n_at2_sh = r_s2_at2 >>> T2_SHIFT;
        n_sqt3   = $signed({1'b0, r_s2_bb[31:SQ_SHIFT]}) * i_coef.t3;

        n_sqt3_sh = r_s3_sqt3 >>> T3_SHIFT;
        n_tf      = r_s3_v1 + $signed(n_sqt3_sh[22:0]);

        // centi-degrees with rounding, then clamp to 16 bits
        n_tf34 = 34'(r_s4_tf);
        n_tc_w = (n_tf34 * 34'sd5 + 34'sd128) >>> 8;
        n_side.tf = r_s4_tf;
        if (n_tc_w > 34'sd32767) begin
            n_side.tc = 16'sh7fff;
        end else if (n_tc_w < -34'sd32768) begin
            n_side.tc = 16'sh8000;
        end else begin
            n_side.tc = n_tc_w[15:0];
        end
        n_x1_w = r_s4_tf - 33'(T_OFFSET);
        n_x1   = n_x1_w[24:0];
        n_x1sq = n_x1 * n_x1;
        n_x1p5 = n_x1 * i_coef.p5;
        n_x1p2 = n_x1 * i_coef.p2;

        n_x2  = r_s7_q6 + ({{23{r_s7_x1p5[40]}}, r_s7_x1p5} << P5_SHIFT)
              + (sext16(i_coef.p4) << P4_SHIFT);
        n_x1b = asr64(r_s7_q3, P3_SHIFT) + ({{23{r_s7_x1p2[40]}}, r_s7_x1p2} << P2_SHIFT)
              + (64'd1 << P1_ONE);

        n_pb = 21'(P_BASE) - {1'b0, r_s8_adcp};
        n_n0 = ({43'd0, n_pb} << NUM_SHIFT) - r_s8_x2;

        // signs split off, magnitudes go to the divider
        n_div.rem  = '0;
        n_div.quo  = r_s11_num[63] ? 64'd0 - r_s11_num : r_s11_num;
        n_div.dvs  = r_s11_den[63] ? 64'd0 - r_s11_den : r_s11_den;
        n_div.neg  = r_s11_num[63] ^ r_s11_den[63];
        n_div.err  = (r_s11_den == 64'd0);
        n_div.side = r_s11_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[11:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_a     <= n_a;
            r_s1_b     <= n_b;
            r_s1_adcp  <= i_item.raw_pressure;

            r_s2_at2   <= n_at2;
            r_s2_bb    <= n_bb[31:0];
            r_s2_adcp  <= r_s1_adcp;

            r_s3_v1    <= n_at2_sh[22:0];
            r_s3_sqt3  <= n_sqt3;
            r_s3_adcp  <= r_s2_adcp;

            r_s4_tf    <= n_tf;
            r_s4_adcp  <= r_s3_adcp;

            r_s5_side  <= n_side;
            r_s5_x1sq  <= {{14{n_x1sq[49]}}, n_x1sq};
            r_s5_x1p5  <= n_x1p5;
            r_s5_x1p2  <= n_x1p2;
            r_s5_adcp  <= r_s4_adcp;

            r_s6_side  <= r_s5_side;
            r_s6_pp6   <= pp_mul(r_s5_x1sq, sext16(i_coef.p6));
            r_s6_pp3   <= pp_mul(r_s5_x1sq, sext16(i_coef.p3));
            r_s6_x1p5  <= r_s5_x1p5;
            r_s6_x1p2  <= r_s5_x1p2;
            r_s6_adcp  <= r_s5_adcp;

            r_s7_side  <= r_s6_side;
            r_s7_q6    <= pp_sum(r_s6_pp6);
            r_s7_q3    <= pp_sum(r_s6_pp3);
            r_s7_x1p5  <= r_s6_x1p5;
            r_s7_x1p2  <= r_s6_x1p2;
            r_s7_adcp  <= r_s6_adcp;

            r_s8_side  <= r_s7_side;
            r_s8_x2    <= n_x2;
            r_s8_x1b   <= n_x1b;
            r_s8_adcp  <= r_s7_adcp;

            r_s9_side  <= r_s8_side;
            r_s9_pp1   <= pp_mul(r_s8_x1b, {48'd0, i_coef.p1});
            r_s9_n0    <= n_n0;

            r_s10_side <= r_s9_side;
            r_s10_den  <= asr64(pp_sum(r_s9_pp1), P1_SHIFT);
            r_s10_ppn  <= pp_mul(r_s9_n0, 64'(P_SCALE));

            r_s11_side <= r_s10_side;
            r_s11_den  <= r_s10_den;
            r_s11_num  <= pp_sum(r_s10_ppn);

            r_s12_div  <= n_div;
        end
    end

    assign o_valid = r_v[12];
    assign o_div   = r_s12_div;

endmodule

// ===== sv/btpc_div.sv =====
// ----------------------------------------------------------------------------
// btpc_div
// pipelined restoring divider on 64-bit magnitudes, one quotient bit a stage
// ----------------------------------------------------------------------------
module btpc_div import btpc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_div i_div,
    output logic o_valid,
    output t_div o_div
);

    logic [DIV_STEPS-1:0] r_v;
    t_div                 r_st [DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[DIV_STEPS-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        t_div        n_prev;
        t_div        n_st;
        logic [63:0] n_try;
        logic        n_ge;

        if (k == 0) begin : g_first
            assign n_prev = i_div;
        end else begin : g_rest
            assign n_prev = r_st[k-1];
        end

        always_comb begin
            n_try     = {n_prev.rem[62:0], n_prev.quo[63]};
            n_ge      = (n_try >= n_prev.dvs);
            n_st      = n_prev;
            n_st.rem  = n_ge ? n_try - n_prev.dvs : n_try;
            // numerator bits leave at the top, quotient bits enter at the bottom
            n_st.quo  = {n_prev.quo[62:0], n_ge};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= n_st;
            end
        end
    end

    assign o_valid = r_v[DIV_STEPS-1];
    assign o_div   = r_st[DIV_STEPS-1];

endmodule

// ===== sv/btpc_back.sv =====
// ----------------------------------------------------------------------------
// btpc_back
// pressure correction terms, clamping and the output register
// ----------------------------------------------------------------------------
module btpc_back import btpc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_div      i_div,
    input  t_coef     i_coef,
    output logic      o_valid,
    output t_out_item o_item
);

    logic [6:1]  r_v;
    logic        r_out_v;

    t_temp       r_b1_side, r_b2_side, r_b3_side, r_b4_side, r_b5_side, r_b6_side;
    logic        r_b1_err, r_b2_err, r_b3_err, r_b4_err, r_b5_err, r_b6_err;
    logic [63:0] r_b1_p, r_b2_p, r_b3_p, r_b4_p, r_b5_p;
    t_pp         r_b2_pp9;
    t_pp         r_b2_pp8;
    logic [63:0] r_b3_p9ps;
    logic [63:0] r_b3_p8p;
    t_pp         r_b4_pp;
    logic [63:0] r_b4_y2, r_b5_y2;
    logic [63:0] r_b5_y1;
    logic [63:0] r_b6_pf;
    t_out_item   r_out;

    logic [63:0] n_p;
    logic [63:0] n_ps2;
    logic [63:0] n_ps4;
    logic [63:0] n_pf;
    t_out_item   n_out;

    always_comb begin
        n_p   = i_div.neg ? 64'd0 - i_div.quo : i_div.quo;
        n_ps2 = asr64(r_b1_p, PS_SHIFT);
        n_ps4 = asr64(r_b3_p, PS_SHIFT);
        n_pf  = asr64(r_b5_p + r_b5_y1 + r_b5_y2, OUT_SHIFT)
              + (sext16(i_coef.p7) << P7_SHIFT);

        n_out.fine_temperature  = r_b6_side.tf;
        n_out.temperature_centi = r_b6_side.tc;
        n_out.divide_error      = r_b6_err;
        if (r_b6_err || r_b6_pf[63]) begin
            n_out.pressure_q24_8 = '0;
        end else if (r_b6_pf[62:32] != '0) begin
            n_out.pressure_q24_8 = '1;
        end else begin
            n_out.pressure_q24_8 = r_b6_pf[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_v     <= {r_v[5:1], i_valid};
            r_out_v <= r_v[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b1_side <= i_div.side;
            r_b1_err  <= i_div.err;
            r_b1_p    <= n_p;

            r_b2_side <= r_b1_side;
            r_b2_err  <= r_b1_err;
            r_b2_p    <= r_b1_p;
            r_b2_pp9  <= pp_mul(sext16(i_coef.p9), n_ps2);
            r_b2_pp8  <= pp_mul(sext16(i_coef.p8), r_b1_p);

            r_b3_side <= r_b2_side;
            r_b3_err  <= r_b2_err;
            r_b3_p    <= r_b2_p;
            r_b3_p9ps <= pp_sum(r_b2_pp9);
            r_b3_p8p  <= pp_sum(r_b2_pp8);

            r_b4_side <= r_b3_side;
            r_b4_err  <= r_b3_err;
            r_b4_p    <= r_b3_p;
            r_b4_pp   <= pp_mul(r_b3_p9ps, n_ps4);
            r_b4_y2   <= asr64(r_b3_p8p, P8_SHIFT);

            r_b5_side <= r_b4_side;
            r_b5_err  <= r_b4_err;
            r_b5_p    <= r_b4_p;
            r_b5_y1   <= asr64(pp_sum(r_b4_pp), P9_SHIFT);
            r_b5_y2   <= r_b4_y2;

            r_b6_side <= r_b5_side;
            r_b6_err  <= r_b5_err;
            r_b6_pf   <= n_pf;

            r_out     <= n_out;
        end
    end

    assign o_valid = r_out_v;
    assign o_item  = r_out;

endmodule

// ===== sv/baro_temp_pressure_compensation.sv =====
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// integer barometer compensation of raw temperature and pressure readings
// ----------------------------------------------------------------------------
// Takes one pair of raw readings per cycle unless o_in_stall is high, and returns
// fine temperature, temperature in 0.01 degC and pressure in Q24.8 pascals
// through 12 front stages, 64 divider stages, 6 correction stages and the
// output register. The pressure divider resolves one quotient bit per stage.
// A stalled output holds the whole pipeline in place. Calibration words are to
// be written through the register port only while no item is in flight; the
// block itself does not enforce this. There is no clearing pass after reset.
module baro_temp_pressure_compensation import btpc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [CFG_WIDTH-1:0] i_cfg_data
);

    logic [CFG_WIDTH-1:0] r_temp_coeffs;
    logic [CFG_WIDTH-1:0] r_pres_low;
    logic [CFG_WIDTH-1:0] r_pres_mid;
    logic [CFG_WIDTH-1:0] r_pres_high;

    t_coef coef;
    logic  en;
    logic  front_valid;
    t_div  front_div;
    logic  div_valid;
    t_div  div_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_coeffs <= '0;
            r_pres_low    <= '0;
            r_pres_mid    <= '0;
            r_pres_high   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TEMP:      r_temp_coeffs <= i_cfg_data;
                CFG_PRES_LOW:  r_pres_low    <= i_cfg_data;
                CFG_PRES_MID:  r_pres_mid    <= i_cfg_data;
                CFG_PRES_HIGH: r_pres_high   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        coef.t1 = r_temp_coeffs[15:0];
        coef.t2 = r_temp_coeffs[31:16];
        coef.t3 = r_temp_coeffs[47:32];
        coef.p1 = r_pres_low[15:0];
        coef.p2 = r_pres_low[31:16];
        coef.p3 = r_pres_low[47:32];
        coef.p4 = r_pres_mid[15:0];
        coef.p5 = r_pres_mid[31:16];
        coef.p6 = r_pres_mid[47:32];
        coef.p7 = r_pres_high[15:0];
        coef.p8 = r_pres_high[31:16];
        coef.p9 = r_pres_high[47:32];
    end

    // pipeline moves unless a finished item is held at the output
    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    btpc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .i_coef  (coef),
        .o_valid (front_valid),
        .o_div   (front_div)
    );

    btpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_valid),
        .i_div   (front_div),
        .o_valid (div_valid),
        .o_div   (div_out)
    );

    btpc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_valid),
        .i_div   (div_out),
        .i_coef  (coef),
        .o_valid (o_out_valid),
        .o_item  (o_out_item)
    );

endmodule

// ===== sim/baro_temp_pressure_compensation_tb.sv =====
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_tb
// self-checking bench for the barometer compensation pipeline
// ----------------------------------------------------------------------------
// Drives raw temperature/pressure pairs through the valid/stall handshake
// under several calibration sets (reset zeros, typical, extremes, random),
// predicts each result with a 64-bit integer model of the compensation and
// compares every output item field by field in arrival order.
`timescale 1ns / 100ps

module baro_temp_pressure_compensation_tb;
    import btpc_pkg::*;

    localparam int RAND_PER_SET = 160;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        t_in_item  raw;
        bit        typed;
        t_out_item result;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in_item;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_item            o_out_item;
    logic                 i_cfg_we;
    logic [1:0]           i_cfg_index;
    logic [CFG_WIDTH-1:0] i_cfg_data;

    logic [CFG_WIDTH-1:0] calib [4];
    t_out_item            pending_results [$];
    int                   n_accepted;
    int                   idle_cycles;
    int                   burst_left;
    bit                   failed;
    bit                   hold_done;
    t_row                 rows [$];

    baro_temp_pressure_compensation i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] sra(input logic [63:0] x, input int n);
        logic signed [63:0] s;
        s = x;
        return s >>> n;
    endfunction

    function automatic logic [63:0] word_s(input logic [47:0] r, input int k);
        logic [15:0] w;
        w = r[16*k +: 16];
        return {{48{w[15]}}, w};
    endfunction

    function automatic t_out_item compensate(input t_in_item it);
        logic [63:0] at, ap, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] a, v1, b, sq, v2, tf, x1, x2, p, num, mn, md, q, ps, y1, y2;
        logic signed [63:0] tc, sp;
        t_out_item r;
        at = {44'd0, it.raw_temperature};
        ap = {44'd0, it.raw_pressure};
        t1 = {48'd0, calib[CFG_TEMP][15:0]};
        t2 = word_s(calib[CFG_TEMP], 1);
        t3 = word_s(calib[CFG_TEMP], 2);
        p1 = {48'd0, calib[CFG_PRES_LOW][15:0]};
        p2 = word_s(calib[CFG_PRES_LOW], 1);
        p3 = word_s(calib[CFG_PRES_LOW], 2);
        p4 = word_s(calib[CFG_PRES_MID], 0);
        p5 = word_s(calib[CFG_PRES_MID], 1);
        p6 = word_s(calib[CFG_PRES_MID], 2);
        p7 = word_s(calib[CFG_PRES_HIGH], 0);
        p8 = word_s(calib[CFG_PRES_HIGH], 1);
        p9 = word_s(calib[CFG_PRES_HIGH], 2);

        a  = (at >> 3) - (t1 << 1);
        v1 = sra(a * t2, 11);
        b  = (at >> 4) - t1;
        sq = sra(b * b, 12);
        v2 = sra(sq * t3, 14);
        tf = v1 + v2;
        tc = sra(tf * 64'd5 + 64'd128, 8);
        if (tc > 32767) tc = 32767;
        if (tc < -32768) tc = -32768;

        x1 = tf - 64'd128000;
        x2 = x1 * x1 * p6;
        x2 = x2 + ((x1 * p5) << 17);
        x2 = x2 + (p4 << 35);
        x1 = sra(x1 * x1 * p3, 8) + ((x1 * p2) << 12);
        x1 = sra(((64'd1 << 47) + x1) * p1, 33);

        r.fine_temperature  = tf[31:0];
        r.temperature_centi = tc[15:0];
        r.pressure_q24_8    = '0;
        r.divide_error      = 1'b0;
        if (x1 == 64'd0) begin
            r.divide_error = 1'b1;
        end else begin
            p   = 64'd1048576 - ap;
            num = ((p << 31) - x2) * 64'd3125;
            mn  = num[63] ? -num : num;
            md  = x1[63] ? -x1 : x1;
            q   = mn / md;
            p   = (num[63] != x1[63]) ? -q : q;
            ps  = sra(p, 13);
            y1  = sra(p9 * ps * ps, 25);
            y2  = sra(p8 * p, 19);
            p   = sra(p + y1 + y2, 8) + (p7 << 4);
            sp  = p;
            if (sp < 0) r.pressure_q24_8 = '0;
            else if (sp > 64'sh0_FFFF_FFFF) r.pressure_q24_8 = 32'hFFFF_FFFF;
            else r.pressure_q24_8 = sp[31:0];
        end
        return r;
    endfunction

    // only called with nothing in flight
    task automatic load_calib(input logic [CFG_WIDTH-1:0] c0, c1, c2, c3);
        logic [CFG_WIDTH-1:0] vals [4];
        vals = '{c0, c1, c2, c3};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= k[1:0];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            calib[k] = vals[k];
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        wait (pending_results.size() == 0);
        repeat (90) @(posedge i_clk);
    endtask

    task automatic send_item(input t_in_item it, input bit typed, input t_out_item fixed);
        int gap;
        i_in_item  <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(typed ? fixed : compensate(it));
        n_accepted++;
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 12);
        end
    endtask

    function automatic t_in_item rand_raw();
        t_in_item it;
        if ($urandom_range(0, 2) == 0) begin
            it.raw_temperature = 20'($urandom_range(0, 20'hFFFFF));
            it.raw_pressure    = 20'($urandom_range(0, 20'hFFFFF));
        end else begin
            it.raw_temperature = 20'($urandom_range(440000, 600000));
            it.raw_pressure    = 20'($urandom_range(250000, 600000));
        end
        return it;
    endfunction

    // typical calibration with some jitter on every word
    function automatic logic [CFG_WIDTH-1:0] jitter(input logic [CFG_WIDTH-1:0] v);
        logic [CFG_WIDTH-1:0] r;
        for (int k = 0; k < 3; k++)
            r[16*k +: 16] = v[16*k +: 16] + 16'($urandom_range(0, 63)) - 16'd32;
        return r;
    endfunction

    task automatic random_set(input int count);
        t_out_item none;
        none = '0;
        for (int n = 0; n < count; n++)
            send_item(rand_raw(), 1'b0, none);
    endtask

    initial begin
        logic [CFG_WIDTH-1:0] typ [4];
        t_out_item none, zero_calib;
        typ[0] = {16'hFC18, 16'd26435, 16'd27504};
        typ[1] = {16'd3024, 16'hD643, 16'd36477};
        typ[2] = {16'hFFF9, 16'd140, 16'd2855};
        typ[3] = {16'd6000, 16'hC6F8, 16'd15500};
        none = '0;
        zero_calib = '{fine_temperature: 0, temperature_centi: 0,
                       pressure_q24_8: 0, divide_error: 1'b1};

        // rows with all-zero calibration: temperature terms vanish, p1 = 0 divides by 0
        rows.push_back('{'{20'h00000, 20'h00000}, 1'b1, zero_calib});
        rows.push_back('{'{20'hFFFFF, 20'hFFFFF}, 1'b1, zero_calib});
        rows.push_back('{'{20'hAAAAA, 20'h55555}, 1'b1, zero_calib});
        rows.push_back('{'{20'h55555, 20'hAAAAA}, 1'b1, zero_calib});
        // rows under typical calibration
        rows.push_back('{'{20'd519888, 20'd415148}, 1'b0, none});
        rows.push_back('{'{20'h00000, 20'h00000}, 1'b0, none});
        rows.push_back('{'{20'hFFFFF, 20'hFFFFF}, 1'b0, none});
        rows.push_back('{'{20'h00000, 20'hFFFFF}, 1'b0, none});
        rows.push_back('{'{20'hFFFFF, 20'h00000}, 1'b0, none});
        rows.push_back('{'{20'hAAAAA, 20'h55555}, 1'b0, none});
        rows.push_back('{'{20'h55555, 20'hAAAAA}, 1'b0, none});
        rows.push_back('{'{20'd440000, 20'd300000}, 1'b0, none});
        rows.push_back('{'{20'd600000, 20'd550000}, 1'b0, none});
        rows.push_back('{'{20'h80000, 20'h80000}, 1'b0, none});

        failed      = 1'b0;
        n_accepted  = 0;
        burst_left  = 5;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_TEMP;
        i_cfg_data  = '0;
        for (int k = 0; k < 4; k++) calib[k] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            if (r == 4) begin
                i_in_valid <= 1'b0;
                wait_idle();
                load_calib(typ[0], typ[1], typ[2], typ[3]);
            end
            send_item(rows[r].raw, rows[r].typed, rows[r].result);
        end
        random_set(RAND_PER_SET);

        for (int s = 0; s < 6; s++) begin
            i_in_valid <= 1'b0;
            wait_idle();
            case (s)
                0: load_calib('1, '1, '1, '1);
                1: load_calib({16'h7FFF, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h7FFF, 16'hFFFF},
                              {3{16'h7FFF}}, {3{16'h7FFF}});
                2: load_calib({16'h8000, 16'h8000, 16'h0000}, {16'h8000, 16'h8000, 16'h0001},
                              {3{16'h8000}}, {3{16'h8000}});
                3, 4: load_calib(jitter(typ[0]), jitter(typ[1]), jitter(typ[2]), jitter(typ[3]));
                default: load_calib(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                                    48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
            endcase
            random_set(RAND_PER_SET);
        end

        i_in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!failed) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // receiver stall pattern, plus one long hold-off mid-run
    initial begin
        int mode;
        i_out_stall = 1'b0;
        hold_done   = 1'b0;
        mode        = 0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && n_accepted >= 400) begin
                hold_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
            end
            if ($urandom_range(0, 99) == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 9) < 3);
                2: i_out_stall <= ($urandom_range(0, 9) < 8);
                default: i_out_stall <= ~i_out_stall;
            endcase
        end
    end

    // result checking
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("output item with no expectation waiting");
                failed = 1'b1;
            end else begin
                want = pending_results.pop_front();
                if (o_out_item.fine_temperature !== want.fine_temperature) begin
                    $error("fine_temperature: expected %0d, got %0d",
                           want.fine_temperature, o_out_item.fine_temperature);
                    failed = 1'b1;
                end
                if (o_out_item.temperature_centi !== want.temperature_centi) begin
                    $error("temperature_centi: expected %0d, got %0d",
                           want.temperature_centi, o_out_item.temperature_centi);
                    failed = 1'b1;
                end
                if (o_out_item.pressure_q24_8 !== want.pressure_q24_8) begin
                    $error("pressure_q24_8: expected %0d, got %0d",
                           want.pressure_q24_8, o_out_item.pressure_q24_8);
                    failed = 1'b1;
                end
                if (o_out_item.divide_error !== want.divide_error) begin
                    $error("divide_error: expected %0d, got %0d",
                           want.divide_error, o_out_item.divide_error);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog on cycles without any item moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
